// ===== src/dfn_pkg.sv =====
// Shared types and constants of the directional focus navigator.
// Used by dfn_cell, dfn_chain and directional_focus_navigator; depends on nothing.
`default_nettype none

package dfn_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VERT,
        ST_VERT_WAIT,
        ST_HORZ,
        ST_HORZ_WAIT,
        ST_FINISH
    } dfn_state_t;

    // Classified stick axis: centred, below or above the dead zone.
    typedef enum logic [1:0] {
        AX_CENTER,
        AX_NEG,
        AX_POS
    } dfn_axis_t;

    // Search direction broadcast to every cell: horiz picks the y axis as
    // the "along" axis, neg flips its sign.
    typedef struct packed {
        logic horiz;
        logic neg;
    } dfn_dir_t;

    // A candidate must score below this bound to be picked.
    localparam int SCORE_LIMIT = 100000;
    localparam int SCORE_MIN_W = 17;

    localparam int AXIS_W     = 12;
    localparam int CFG_W      = 12;
    localparam int CNT_REG_W  = 7;
    localparam int PORT_IDX_W = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_X_CENTER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CENTER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd3;

    localparam logic [AXIS_W-1:0]    X_CENTER_RST    = 12'd1935;
    localparam logic [AXIS_W-1:0]    Y_CENTER_RST    = 12'd1880;
    localparam logic [AXIS_W-1:0]    DEAD_ZONE_RST   = 12'd800;
    localparam logic [CNT_REG_W-1:0] ENTRY_COUNT_RST = 7'd0;

endpackage

`default_nettype wire

// ===== src/dfn_cell.sv =====
// One cell of the search chain: holds one table point and scores the passing
// search token against it. Depends on dfn_pkg.
`default_nettype none

module dfn_cell #(
    parameter int CELL_IDX    = 0,
    parameter int COORD_WIDTH = 12,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7,
    parameter int SCORE_W     = 17
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            wr_en,
    input  wire logic signed [COORD_WIDTH-1:0] wr_x,
    input  wire logic signed [COORD_WIDTH-1:0] wr_y,
    input  wire                            wr_vis,
    input  wire dfn_pkg::dfn_dir_t         dir,
    input  wire logic signed [COORD_WIDTH-1:0] org_x,
    input  wire logic signed [COORD_WIDTH-1:0] org_y,
    input  wire logic [IDX_W-1:0]          from_idx,
    input  wire logic [CNT_W-1:0]          live_n,
    input  wire                            in_valid,
    input  wire logic [SCORE_W-1:0]        in_score,
    input  wire                            in_found,
    input  wire logic [IDX_W-1:0]          in_idx,
    input  wire logic signed [COORD_WIDTH-1:0] in_x,
    input  wire logic signed [COORD_WIDTH-1:0] in_y,
    output logic                           out_valid,
    output logic [SCORE_W-1:0]             out_score,
    output logic                           out_found,
    output logic [IDX_W-1:0]               out_idx,
    output logic signed [COORD_WIDTH-1:0]  out_x,
    output logic signed [COORD_WIDTH-1:0]  out_y
);
    import dfn_pkg::*;

    localparam int DW = COORD_WIDTH + 2;

    logic signed [COORD_WIDTH-1:0] x_reg;
    logic signed [COORD_WIDTH-1:0] y_reg;
    logic                          vis_reg;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] along;
    logic signed [DW-1:0] perp_raw;
    logic signed [DW-1:0] perp_neg;
    logic [COORD_WIDTH:0] perp_abs;
    logic                 along_pos;
    logic [SCORE_W-1:0]   score;
    logic                 hit;

    logic                          valid_reg;
    logic [SCORE_W-1:0]            score_reg;
    logic                          found_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic signed [COORD_WIDTH-1:0] bx_reg;
    logic signed [COORD_WIDTH-1:0] by_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_reg   <= wr_x;
            y_reg   <= wr_y;
            vis_reg <= wr_vis;
        end
    end

    always_comb
    begin
        dx       = DW'(x_reg) - DW'(org_x);
        dy       = DW'(y_reg) - DW'(org_y);
        along    = dir.horiz ? (dir.neg ? -dy : dy) : (dir.neg ? -dx : dx);
        perp_raw = dir.horiz ? dx : dy;
        perp_neg = -perp_raw;
        perp_abs = perp_raw[DW-1] ? perp_neg[COORD_WIDTH:0] : perp_raw[COORD_WIDTH:0];
        along_pos = !along[DW-1] && (along != '0);
        score    = SCORE_W'(along[COORD_WIDTH:0]) + (SCORE_W'(perp_abs) << 1);
        hit      = in_valid && (CNT_W'(CELL_IDX) < live_n)
                   && (IDX_W'(CELL_IDX) != from_idx) && vis_reg
                   && along_pos && (score < in_score);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // Take the point over on a better score, else pass the token on.
    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            score_reg <= score;
            found_reg <= 1'b1;
            idx_reg   <= IDX_W'(CELL_IDX);
            bx_reg    <= x_reg;
            by_reg    <= y_reg;
        end
        else
        begin
            score_reg <= in_score;
            found_reg <= in_found;
            idx_reg   <= in_idx;
            bx_reg    <= in_x;
            by_reg    <= in_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_score = score_reg;
    assign out_found = found_reg;
    assign out_idx   = idx_reg;
    assign out_x     = bx_reg;
    assign out_y     = by_reg;

endmodule

`default_nettype wire

// ===== src/dfn_chain.sv =====
// Row of dfn_cell instances: one cell per table slot, the search token moves
// one cell per clock. Depends on dfn_pkg and dfn_cell.
`default_nettype none

module dfn_chain #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_WIDTH = 12,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7,
    parameter int SCORE_W     = 17
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                wr_en,
    input  wire logic [IDX_W-1:0]              wr_idx,
    input  wire logic signed [COORD_WIDTH-1:0] wr_x,
    input  wire logic signed [COORD_WIDTH-1:0] wr_y,
    input  wire                                wr_vis,
    input  wire                                launch,
    input  wire dfn_pkg::dfn_dir_t             dir,
    input  wire logic signed [COORD_WIDTH-1:0] org_x,
    input  wire logic signed [COORD_WIDTH-1:0] org_y,
    input  wire logic [IDX_W-1:0]              from_idx,
    input  wire logic [CNT_W-1:0]              live_n,
    output logic                               res_valid,
    output logic                               res_found,
    output logic [IDX_W-1:0]                   res_idx,
    output logic signed [COORD_WIDTH-1:0]      res_x,
    output logic signed [COORD_WIDTH-1:0]      res_y
);
    import dfn_pkg::*;

    logic                          tok_valid [0:MAX_ENTRIES];
    logic [SCORE_W-1:0]            tok_score [0:MAX_ENTRIES];
    logic                          tok_found [0:MAX_ENTRIES];
    logic [IDX_W-1:0]              tok_idx   [0:MAX_ENTRIES];
    logic signed [COORD_WIDTH-1:0] tok_x     [0:MAX_ENTRIES];
    logic signed [COORD_WIDTH-1:0] tok_y     [0:MAX_ENTRIES];

    // Fresh token: nothing found yet, best score at the limit.
    assign tok_valid[0] = launch;
    assign tok_score[0] = SCORE_W'(SCORE_LIMIT);
    assign tok_found[0] = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_x[0]     = '0;
    assign tok_y[0]     = '0;

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        dfn_cell #(
            .CELL_IDX    (i),
            .COORD_WIDTH (COORD_WIDTH),
            .IDX_W       (IDX_W),
            .CNT_W       (CNT_W),
            .SCORE_W     (SCORE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr_en     (wr_en && (wr_idx == IDX_W'(i))),
            .wr_x      (wr_x),
            .wr_y      (wr_y),
            .wr_vis    (wr_vis),
            .dir       (dir),
            .org_x     (org_x),
            .org_y     (org_y),
            .from_idx  (from_idx),
            .live_n    (live_n),
            .in_valid  (tok_valid[i]),
            .in_score  (tok_score[i]),
            .in_found  (tok_found[i]),
            .in_idx    (tok_idx[i]),
            .in_x      (tok_x[i]),
            .in_y      (tok_y[i]),
            .out_valid (tok_valid[i+1]),
            .out_score (tok_score[i+1]),
            .out_found (tok_found[i+1]),
            .out_idx   (tok_idx[i+1]),
            .out_x     (tok_x[i+1]),
            .out_y     (tok_y[i+1])
        );
    end

    assign res_valid = tok_valid[MAX_ENTRIES];
    assign res_found = tok_found[MAX_ENTRIES];
    assign res_idx   = tok_idx[MAX_ENTRIES];
    assign res_x     = tok_x[MAX_ENTRIES];
    assign res_y     = tok_y[MAX_ENTRIES];

endmodule

`default_nettype wire

// ===== src/directional_focus_navigator.sv =====
// Top level of the directional focus navigator: sequencer, stick classifier,
// selection state and config registers. Depends on dfn_pkg and dfn_chain.
`default_nettype none

// Usage
//   Input transactions are taken at a rising edge with start high and busy
//   low. opcode selects a table load or a joystick sample.
//   A load writes one point into its chain cell in the accepting edge, gives
//   no result and leaves busy low, so loads may come every cycle.
//   A sample raises busy and yields exactly one result transaction: the
//   result ports are valid for the single cycle in which done is high.
//   A sample's latency is set by the search token walking the cell chain
//   one slot per clock, once per triggered axis; the vertical walk runs
//   before the horizontal one.
//   Results are held through the done cycle and a new start may be taken
//   in that same cycle. The receiver cannot stall, so done never waits.
//   Config writes (cfg_we, cfg_index, cfg_data) land at the clock edge and
//   belong in idle periods only.
//   Reset: centers and dead zone return to their defaults, entry_count to
//   zero, selection to slot 0, no confirmation, axes centred, button
//   released. Table contents are not cleared; load a slot before use.
module directional_focus_navigator #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_WIDTH = 12
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire                                         start,
    output logic                                        busy,
    input  wire                                         opcode,
    input  wire logic [dfn_pkg::PORT_IDX_W-1:0]         entry_index,
    input  wire logic signed [COORD_WIDTH-1:0]          pos_x,
    input  wire logic signed [COORD_WIDTH-1:0]          pos_y,
    input  wire                                         in_range,
    input  wire logic [dfn_pkg::AXIS_W-1:0]             x_axis_raw,
    input  wire logic [dfn_pkg::AXIS_W-1:0]             y_axis_raw,
    input  wire                                         button_level,
    output logic                                        done,
    output logic [dfn_pkg::PORT_IDX_W-1:0]              selected_index,
    output logic                                        selection_changed,
    output logic                                        confirm_event,
    output logic                                        confirmed_valid,
    output logic [dfn_pkg::PORT_IDX_W-1:0]              confirmed_index,
    input  wire                                         cfg_we,
    input  wire logic [dfn_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [dfn_pkg::CFG_W-1:0]              cfg_data
);
    import dfn_pkg::*;

    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W   = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
    localparam int SLOT_W  = (CNT_W > PORT_IDX_W) ? CNT_W : PORT_IDX_W;
    localparam int SCORE_W = (COORD_WIDTH + 2 > SCORE_MIN_W) ? COORD_WIDTH + 2 : SCORE_MIN_W;

    // Classify one ADC reading: below center - dz, above center + dz, or centred.
    function automatic dfn_axis_t classify(input logic [AXIS_W-1:0] raw,
                                           input logic [AXIS_W-1:0] center,
                                           input logic [AXIS_W-1:0] dz);
        logic [AXIS_W:0] r_plus_d;
        logic [AXIS_W:0] c_plus_d;
        r_plus_d = {1'b0, raw} + {1'b0, dz};
        c_plus_d = {1'b0, center} + {1'b0, dz};
        if (r_plus_d < {1'b0, center})
            return AX_NEG;
        else if ({1'b0, raw} > c_plus_d)
            return AX_POS;
        else
            return AX_CENTER;
    endfunction

    dfn_state_t state_reg, state_next;

    logic [AXIS_W-1:0]    x_center_reg;
    logic [AXIS_W-1:0]    y_center_reg;
    logic [AXIS_W-1:0]    dead_zone_reg;
    logic [CNT_REG_W-1:0] entry_count_reg;

    logic [IDX_W-1:0]              sel_reg, sel_next;
    logic signed [COORD_WIDTH-1:0] sel_x_reg, sel_x_next;
    logic signed [COORD_WIDTH-1:0] sel_y_reg, sel_y_next;
    dfn_axis_t                     vs_reg, vs_next;
    dfn_axis_t                     hs_reg, hs_next;
    logic                          btn_reg, btn_next;
    dfn_axis_t                     prev_vs_reg, prev_vs_next;
    dfn_axis_t                     prev_hs_reg, prev_hs_next;
    logic                          prev_btn_reg, prev_btn_next;
    logic                          changed_reg, changed_next;
    logic                          confirm_reg, confirm_next;
    logic                          conf_valid_reg, conf_valid_next;
    logic [IDX_W-1:0]              conf_idx_reg, conf_idx_next;
    logic                          done_reg, done_next;

    logic             accept;
    logic             sample_acc;
    logic             slot_ok;
    logic             load_acc;
    logic [LIM_W-1:0] count_ext;
    logic [CNT_W-1:0] live_n;
    logic             can_search;
    logic             v_trig;
    logic             h_trig;
    logic             launch;
    logic             apply;
    logic             finish;
    logic             press;
    dfn_dir_t         dir;

    logic                          res_valid;
    logic                          res_found;
    logic [IDX_W-1:0]              res_idx;
    logic signed [COORD_WIDTH-1:0] res_x;
    logic signed [COORD_WIDTH-1:0] res_y;

    // Handshake and load decode.
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign sample_acc = accept && (opcode == OP_SAMPLE);
    assign slot_ok    = SLOT_W'(entry_index) < SLOT_W'(MAX_ENTRIES);
    assign load_acc   = accept && (opcode == OP_LOAD) && slot_ok;

    // Clamp the programmed count to the table depth.
    assign count_ext  = LIM_W'(entry_count_reg);
    assign live_n     = (count_ext > LIM_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                          : CNT_W'(count_ext);
    // An empty table or a stale selection moves nothing.
    assign can_search = (live_n != '0) && (CNT_W'(sel_reg) < live_n);

    assign v_trig = (vs_reg != AX_CENTER) && (vs_reg != prev_vs_reg);
    assign h_trig = (hs_reg != AX_CENTER) && (hs_reg != prev_hs_reg);
    assign press  = !btn_reg && prev_btn_reg;

    // Vertical deflection walks along x (down stick toward +x), horizontal
    // deflection walks along y (left stick toward -y).
    always_comb
    begin
        dir.horiz = (state_reg == ST_HORZ) || (state_reg == ST_HORZ_WAIT);
        dir.neg   = dir.horiz ? (hs_reg == AX_NEG) : (vs_reg == AX_POS);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                    state_next = ST_VERT;
            end
            ST_VERT:
            begin
                if (v_trig && can_search)
                    state_next = ST_VERT_WAIT;
                else
                    state_next = ST_HORZ;
            end
            ST_VERT_WAIT:
            begin
                if (res_valid)
                    state_next = ST_HORZ;
            end
            ST_HORZ:
            begin
                if (h_trig && can_search)
                    state_next = ST_HORZ_WAIT;
                else
                    state_next = ST_FINISH;
            end
            ST_HORZ_WAIT:
            begin
                if (res_valid)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        launch = 1'b0;
        apply  = 1'b0;
        finish = 1'b0;
        case (state_reg)
            ST_VERT:      launch = v_trig && can_search;
            ST_VERT_WAIT: apply  = res_valid && res_found;
            ST_HORZ:      launch = h_trig && can_search;
            ST_HORZ_WAIT: apply  = res_valid && res_found;
            ST_FINISH:    finish = 1'b1;
            default:
            begin
                launch = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        sel_next        = sel_reg;
        sel_x_next      = sel_x_reg;
        sel_y_next      = sel_y_reg;
        vs_next         = vs_reg;
        hs_next         = hs_reg;
        btn_next        = btn_reg;
        prev_vs_next    = prev_vs_reg;
        prev_hs_next    = prev_hs_reg;
        prev_btn_next   = prev_btn_reg;
        changed_next    = changed_reg;
        confirm_next    = confirm_reg;
        conf_valid_next = conf_valid_reg;
        conf_idx_next   = conf_idx_reg;
        done_next       = finish;

        // Capture the sample: classify both axes at the accepting edge.
        if (sample_acc)
        begin
            vs_next      = classify(y_axis_raw, y_center_reg, dead_zone_reg);
            hs_next      = classify(x_axis_raw, x_center_reg, dead_zone_reg);
            btn_next     = button_level;
            changed_next = 1'b0;
        end

        // Keep the origin copy in step with the selected slot's contents.
        if (load_acc && (SLOT_W'(entry_index) == SLOT_W'(sel_reg)))
        begin
            sel_x_next = pos_x;
            sel_y_next = pos_y;
        end

        // Move to the search winner; its coordinates ride in the token.
        if (apply)
        begin
            sel_next     = res_idx;
            sel_x_next   = res_x;
            sel_y_next   = res_y;
            changed_next = 1'b1;
        end

        // Close the sample: confirm on a press edge, advance the history.
        if (finish)
        begin
            confirm_next  = press;
            if (press)
            begin
                conf_valid_next = 1'b1;
                conf_idx_next   = sel_reg;
            end
            prev_vs_next  = vs_reg;
            prev_hs_next  = hs_reg;
            prev_btn_next = btn_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sel_reg        <= '0;
            prev_vs_reg    <= AX_CENTER;
            prev_hs_reg    <= AX_CENTER;
            prev_btn_reg   <= 1'b1;
            changed_reg    <= 1'b0;
            confirm_reg    <= 1'b0;
            conf_valid_reg <= 1'b0;
            conf_idx_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sel_reg        <= sel_next;
            prev_vs_reg    <= prev_vs_next;
            prev_hs_reg    <= prev_hs_next;
            prev_btn_reg   <= prev_btn_next;
            changed_reg    <= changed_next;
            confirm_reg    <= confirm_next;
            conf_valid_reg <= conf_valid_next;
            conf_idx_reg   <= conf_idx_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers: sample capture and origin copy.
    always_ff @(posedge clk)
    begin
        sel_x_reg <= sel_x_next;
        sel_y_reg <= sel_y_next;
        vs_reg    <= vs_next;
        hs_reg    <= hs_next;
        btn_reg   <= btn_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_center_reg    <= X_CENTER_RST;
            y_center_reg    <= Y_CENTER_RST;
            dead_zone_reg   <= DEAD_ZONE_RST;
            entry_count_reg <= ENTRY_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_CENTER:    x_center_reg    <= cfg_data;
                REG_Y_CENTER:    y_center_reg    <= cfg_data;
                REG_DEAD_ZONE:   dead_zone_reg   <= cfg_data;
                REG_ENTRY_COUNT: entry_count_reg <= cfg_data[CNT_REG_W-1:0];
                default:
                begin
                    x_center_reg <= x_center_reg;
                end
            endcase
        end
    end

    dfn_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_WIDTH (COORD_WIDTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W),
        .SCORE_W     (SCORE_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (load_acc),
        .wr_idx    (IDX_W'(entry_index)),
        .wr_x      (pos_x),
        .wr_y      (pos_y),
        .wr_vis    (in_range),
        .launch    (launch),
        .dir       (dir),
        .org_x     (sel_x_reg),
        .org_y     (sel_y_reg),
        .from_idx  (sel_reg),
        .live_n    (live_n),
        .res_valid (res_valid),
        .res_found (res_found),
        .res_idx   (res_idx),
        .res_x     (res_x),
        .res_y     (res_y)
    );

    // Result ports hold steady through the done cycle.
    assign done              = done_reg;
    assign selected_index    = PORT_IDX_W'(sel_reg);
    assign selection_changed = changed_reg;
    assign confirm_event     = confirm_reg;
    assign confirmed_valid   = conf_valid_reg;
    assign confirmed_index   = PORT_IDX_W'(conf_idx_reg);

endmodule

`default_nettype wire

// ===== test/tb_directional_focus_navigator.sv =====
// Self-checking testbench of directional_focus_navigator: directed and random transactions
// through the start/busy port, predicted in-line and compared against each done strobe.
// Depends on dfn_pkg and the directional_focus_navigator RTL only.
module tb_directional_focus_navigator;
    import dfn_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int COORD_W       = 12;
    // Slowest legal run: ~2000 full two-walk samples plus gaps, taken ~5x over.
    localparam int CYCLE_LIMIT   = 1500000;
    // One full two-walk sample plus margin; used only at the very end.
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 10;
    // Loads finish in their accepting edge, so a short pause covers register writes.
    localparam int CFG_SETTLE    = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 185;
    // Phase that runs with no idle gaps at all.
    localparam int NO_IDLE_PHASE = 6;

    // One input transaction, every field at its port width.
    typedef struct {
        logic                      opcode;
        logic [PORT_IDX_W-1:0]     slot;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic                      visible;
        logic [AXIS_W-1:0]         x_raw;
        logic [AXIS_W-1:0]         y_raw;
        logic                      button;
    } nav_cmd_t;

    // One result transaction as it should appear while done is high.
    typedef struct {
        logic [PORT_IDX_W-1:0] sel;
        logic                  moved;
        logic                  confirm;
        logic                  conf_valid;
        logic [PORT_IDX_W-1:0] conf_idx;
    } nav_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic                      opcode;
    logic [PORT_IDX_W-1:0]     entry_index;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic                      in_range;
    logic [AXIS_W-1:0]         x_axis_raw;
    logic [AXIS_W-1:0]         y_axis_raw;
    logic                      button_level;
    logic                      done;
    logic [PORT_IDX_W-1:0]     selected_index;
    logic                      selection_changed;
    logic                      confirm_event;
    logic                      confirmed_valid;
    logic [PORT_IDX_W-1:0]     confirmed_index;
    logic                      cfg_we;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_W-1:0]          cfg_data;

    // Shadow of the point table and the navigation state.
    int          pt_x [TABLE_DEPTH];
    int          pt_y [TABLE_DEPTH];
    bit          pt_vis [TABLE_DEPTH];
    int          sel_now;
    bit          any_confirmed;
    int          confirmed_at;
    dfn_axis_t   last_vert;
    dfn_axis_t   last_horz;
    logic        last_button;

    // Shadow of the configuration registers.
    int          x_center;
    int          y_center;
    int          dead_band;
    int          count_reg;

    nav_result_t pending_results [$];
    nav_result_t head_result;
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_enabled = 1'b1;

    directional_focus_navigator #(
        .MAX_ENTRIES (TABLE_DEPTH),
        .COORD_WIDTH (COORD_W)
    ) u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .opcode            (opcode),
        .entry_index       (entry_index),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .in_range          (in_range),
        .x_axis_raw        (x_axis_raw),
        .y_axis_raw        (y_axis_raw),
        .button_level      (button_level),
        .done              (done),
        .selected_index    (selected_index),
        .selection_changed (selection_changed),
        .confirm_event     (confirm_event),
        .confirmed_valid   (confirmed_valid),
        .confirmed_index   (confirmed_index),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Place a reading below, inside or above the dead band of its axis.
    function automatic dfn_axis_t classify_axis(int raw, int center);
        if (raw < center - dead_band)
            return AX_NEG;
        if (raw > center + dead_band)
            return AX_POS;
        return AX_CENTER;
    endfunction

    // Walk the live part of the table from the current selection and return the visible
    // point ahead along (dir_x, dir_y) with the lowest along + 2*|perp|; -1 when none.
    // An empty table or a selection at or past the count finds nothing.
    function automatic int nearest_ahead(int dir_x, int dir_y);
        int live;
        int best;
        int best_score;
        int dx;
        int dy;
        int along;
        int perp;
        int score;
        live = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
        best = -1;
        best_score = SCORE_LIMIT;
        if (live == 0 || sel_now >= live)
            return -1;
        for (int i = 0; i < live; i++)
        begin
            if (i == sel_now || !pt_vis[i])
                continue;
            dx = pt_x[i] - pt_x[sel_now];
            dy = pt_y[i] - pt_y[sel_now];
            along = dx * dir_x + dy * dir_y;
            if (along <= 0)
                continue;
            perp = dx * dir_y - dy * dir_x;
            if (perp < 0)
                perp = -perp;
            score = along + 2 * perp;
            // Strict compare keeps the lowest index on a tie.
            if (score < best_score)
            begin
                best_score = score;
                best = i;
            end
        end
        return best;
    endfunction

    // Advance the shadow state by one joystick sample and return its result.
    function automatic nav_result_t apply_sample(nav_cmd_t c);
        nav_result_t r;
        dfn_axis_t   v;
        dfn_axis_t   h;
        int          target;
        r.moved = 1'b0;
        r.confirm = 1'b0;

        // Vertical first: stick down (NEG) looks toward +x, up toward -x.
        v = classify_axis(int'(c.y_raw), y_center);
        if (v != AX_CENTER && v != last_vert)
        begin
            target = nearest_ahead(v == AX_NEG ? 1 : -1, 0);
            if (target >= 0)
            begin
                sel_now = target;
                r.moved = 1'b1;
            end
        end

        // Horizontal second, from the possibly updated selection.
        h = classify_axis(int'(c.x_raw), x_center);
        if (h != AX_CENTER && h != last_horz)
        begin
            target = nearest_ahead(0, h == AX_NEG ? -1 : 1);
            if (target >= 0)
            begin
                sel_now = target;
                r.moved = 1'b1;
            end
        end

        // Press edge (released -> pressed) latches the selection.
        if (c.button == 1'b0 && last_button == 1'b1)
        begin
            confirmed_at = sel_now;
            any_confirmed = 1'b1;
            r.confirm = 1'b1;
        end

        last_vert = v;
        last_horz = h;
        last_button = c.button;

        r.sel = PORT_IDX_W'(sel_now);
        r.conf_valid = any_confirmed;
        r.conf_idx = any_confirmed ? PORT_IDX_W'(confirmed_at) : '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Transaction builders
    // ------------------------------------------------------------------

    function automatic nav_cmd_t make_load(int slot, int x, int y, logic vis);
        nav_cmd_t c;
        c.opcode = OP_LOAD;
        c.slot = PORT_IDX_W'(slot);
        c.px = COORD_W'(x);
        c.py = COORD_W'(y);
        c.visible = vis;
        // Sample fields ride along as noise; a load must not touch the history.
        c.x_raw = AXIS_W'($urandom);
        c.y_raw = AXIS_W'($urandom);
        c.button = 1'($urandom);
        return c;
    endfunction

    function automatic nav_cmd_t make_sample(int xr, int yr, logic btn);
        nav_cmd_t c;
        c.opcode = OP_SAMPLE;
        // Load fields are don't-care on a sample; scramble them.
        c.slot = PORT_IDX_W'($urandom);
        c.px = COORD_W'($urandom);
        c.py = COORD_W'($urandom);
        c.visible = 1'($urandom);
        c.x_raw = AXIS_W'(xr);
        c.y_raw = AXIS_W'(yr);
        c.button = btn;
        return c;
    endfunction

    // Pick a reading in the wanted class; fall back to anything if the class is empty.
    function automatic int pick_raw(dfn_axis_t want, int center);
        int lo;
        int hi;
        case (want)
            AX_NEG:
            begin
                hi = center - dead_band - 1;
                if (hi >= 0)
                    return $urandom_range(hi, 0);
            end
            AX_POS:
            begin
                lo = center + dead_band + 1;
                if (lo <= 4095)
                    return $urandom_range(4095, lo);
            end
            default:
            begin
                lo = (center - dead_band < 0) ? 0 : center - dead_band;
                hi = (center + dead_band > 4095) ? 4095 : center + dead_band;
                return $urandom_range(hi, lo);
            end
        endcase
        return $urandom_range(4095, 0);
    endfunction

    // Often return to centre between deflections so new edges keep firing searches.
    function automatic int axis_reading(int center);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10)
            return $urandom_range(4095, 0);
        if (roll < 37)
            return pick_raw(AX_NEG, center);
        if (roll < 64)
            return pick_raw(AX_POS, center);
        return pick_raw(AX_CENTER, center);
    endfunction

    // Coarse grid most of the time so ties and collinear points show up.
    function automatic int random_coord();
        if ($urandom_range(99) < 60)
            return 16 * ($urandom_range(16) - 8);
        return $urandom_range(4095, 0) - 2048;
    endfunction

    function automatic nav_cmd_t random_load(int slot);
        return make_load(slot, random_coord(), random_coord(), $urandom_range(99) < 85);
    endfunction

    function automatic nav_cmd_t random_item();
        int live;
        int slot;
        if ($urandom_range(99) < 25)
        begin
            live = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : count_reg;
            // With a live region, half the loads or more land in it and change searches.
            if (live > 0 && $urandom_range(1))
                slot = $urandom_range(live - 1, 0);
            else
                slot = $urandom_range(TABLE_DEPTH - 1, 0);
            return random_load(slot);
        end
        return make_sample(axis_reading(x_center), axis_reading(y_center),
                           $urandom_range(99) >= 45);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Send one transaction: drive at the falling edge, hold until accepted at a rising
    // edge with busy low, then predict. Leave start high; the next call or
    // release_start decides what it does at the following falling edge.
    task automatic send_cmd(nav_cmd_t c);
        @(negedge clk);
        while (idle_enabled && $urandom_range(99) < 32)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start        <= 1'b1;
        opcode       <= c.opcode;
        entry_index  <= c.slot;
        pos_x        <= c.px;
        pos_y        <= c.py;
        in_range     <= c.visible;
        x_axis_raw   <= c.x_raw;
        y_axis_raw   <= c.y_raw;
        button_level <= c.button;
        do
            @(posedge clk);
        while (busy);
        if (c.opcode == OP_SAMPLE)
            pending_results.push_back(apply_sample(c));
        else
        begin
            pt_x[c.slot] = int'(c.px);
            pt_y[c.slot] = int'(c.py);
            pt_vis[c.slot] = c.visible;
        end
    endtask

    task automatic release_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    // Drop start and hold until every outstanding sample has reported.
    task automatic wait_idle();
        release_start();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_X_CENTER:    x_center = int'(value);
            REG_Y_CENTER:    y_center = int'(value);
            REG_DEAD_ZONE:   dead_band = int'(value);
            REG_ENTRY_COUNT: count_reg = int'(value[CNT_REG_W-1:0]);
            default: ;
        endcase
    endtask

    // Rewrite all four registers once the block has gone quiet.
    task automatic set_config(int xc, int yc, int dz, int cnt);
        wait_idle();
        write_reg(REG_X_CENTER, CFG_W'(xc));
        write_reg(REG_Y_CENTER, CFG_W'(yc));
        write_reg(REG_DEAD_ZONE, CFG_W'(dz));
        write_reg(REG_ENTRY_COUNT, CFG_W'(cnt));
    endtask

    // ------------------------------------------------------------------
    // Result checking: every done strobe is one result transaction
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [PORT_IDX_W-1:0] want,
                               logic [PORT_IDX_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no sample outstanding: selected_index %0d",
                       selected_index);
                error_count++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                check_field("selected_index", head_result.sel, selected_index);
                check_field("selection_changed", head_result.moved, selection_changed);
                check_field("confirm_event", head_result.confirm, confirm_event);
                check_field("confirmed_valid", head_result.conf_valid, confirmed_valid);
                check_field("confirmed_index", head_result.conf_idx, confirmed_index);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("directional_focus_navigator verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Count is zero after reset: deflections move nothing, the button still confirms.
    task automatic test_empty_table();
        send_cmd(make_sample(4095, 0, 1'b1));
        send_cmd(make_sample(0, 4095, 1'b0));
        send_cmd(make_sample(1935, 1880, 1'b1));
    endtask

    // Small known layout: a tie on score, an invisible closer point, a point with zero
    // along-distance, coordinate extremes, and the top slot outside the count.
    task automatic test_table_load();
        send_cmd(make_load(0, 0, 0, 1'b1));
        send_cmd(make_load(1, 100, 0, 1'b1));
        send_cmd(make_load(2, 50, 30, 1'b1));
        send_cmd(make_load(3, 60, -20, 1'b1));
        send_cmd(make_load(4, -2048, 2047, 1'b1));
        send_cmd(make_load(5, 2047, -2048, 1'b1));
        send_cmd(make_load(6, 30, 0, 1'b0));
        send_cmd(make_load(7, 0, 200, 1'b1));
        send_cmd(make_load(63, 2047, 2047, 1'b0));
    endtask

    // Each direction, a held deflection that must not search again, and both axes with
    // a press in one sample.
    task automatic test_axis_search();
        set_config(X_CENTER_RST, Y_CENTER_RST, DEAD_ZONE_RST, 8);
        send_cmd(make_sample(1935, 0, 1'b1));
        send_cmd(make_sample(1935, 1880, 1'b1));
        send_cmd(make_sample(1935, 4095, 1'b1));
        send_cmd(make_sample(1935, 4095, 1'b1));
        send_cmd(make_sample(0, 1880, 1'b1));
        send_cmd(make_sample(4095, 0, 1'b0));
        send_cmd(make_sample(1935, 1880, 1'b1));
    endtask

    // Shrink the count to the current selection so the selection goes stale.
    task automatic test_stale_selection();
        wait_idle();
        set_config(X_CENTER_RST, Y_CENTER_RST, DEAD_ZONE_RST, sel_now);
        send_cmd(make_sample(0, 0, 1'b0));
        send_cmd(make_sample(4095, 4095, 1'b1));
    endtask

    // Fill the whole table first so no search ever reads an unwritten slot, then run
    // phases under extreme and random register settings.
    task automatic test_random_traffic();
        int cnt;
        for (int s = 0; s < TABLE_DEPTH; s++)
            send_cmd(random_load(s));
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: set_config(X_CENTER_RST, Y_CENTER_RST, DEAD_ZONE_RST, TABLE_DEPTH);
                1: set_config(0, 0, 0, 127);
                2: set_config(4095, 4095, 4095, 1);
                3: set_config(2048, 2048, 0, TABLE_DEPTH + 1);
                4: set_config(4095, 0, 10, 0);
                default:
                begin
                    cnt = ($urandom_range(99) < 15) ? TABLE_DEPTH : $urandom_range(64, 2);
                    // Scramble the data bits above the count register's width.
                    cnt = cnt | ($urandom_range(31) << CNT_REG_W);
                    set_config($urandom_range(4095), $urandom_range(4095),
                               $urandom_range(1500), cnt);
                end
            endcase
            idle_enabled = (p != NO_IDLE_PHASE);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_cmd(random_item());
        end
        idle_enabled = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_LOAD;
        entry_index  = '0;
        pos_x        = '0;
        pos_y        = '0;
        in_range     = 1'b0;
        x_axis_raw   = AXIS_W'(X_CENTER_RST);
        y_axis_raw   = AXIS_W'(Y_CENTER_RST);
        button_level = 1'b1;
        cfg_we       = 1'b0;
        cfg_index    = REG_X_CENTER;
        cfg_data     = '0;

        sel_now       = 0;
        any_confirmed = 1'b0;
        confirmed_at  = 0;
        last_vert     = AX_CENTER;
        last_horz     = AX_CENTER;
        last_button   = 1'b1;
        x_center      = int'(X_CENTER_RST);
        y_center      = int'(Y_CENTER_RST);
        dead_band     = int'(DEAD_ZONE_RST);
        count_reg     = int'(ENTRY_COUNT_RST);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_table_load();
        test_axis_search();
        test_stale_selection();
        test_random_traffic();

        // Drain, then give a stray extra strobe time to show up.
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("directional_focus_navigator verification clean");
        else
            $display("directional_focus_navigator verification failed");
        $finish;
    end

endmodule
